// ===== hdl/rme_pkg.sv =====
// Package for the rotation matrix to Euler angle block: types, constants,
// the CORDIC arctangent table and small helpers. No dependencies.
`default_nettype none
package rme_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQ_STEPS     = 23;
	localparam int XY_W         = 42;
	localparam int Z_W          = 24;
	localparam int N_W          = 46;

	localparam logic [1:0] ORD_XYZ = 2'd0;
	localparam logic [1:0] ORD_XZY = 2'd1;
	localparam logic [1:0] ORD_YZX = 2'd2;

	localparam logic signed [16:0] ONE_Q14    = 17'sd16384;
	localparam logic signed [Z_W-1:0] ZPI     = 24'sd3294199;
	localparam logic signed [15:0] Q13_PI      = 16'sd25736;
	localparam logic signed [15:0] Q13_HALF_PI = 16'sd12868;

	typedef struct packed {
		logic signed [16:0] ay;
		logic signed [16:0] ax;
		logic signed [16:0] by;
		logic signed [16:0] bx;
		logic signed [16:0] s;
		logic               lock_pos;
		logic               lock_neg;
		logic [1:0]         order;
	} side_t;

	typedef struct packed {
		logic           v;
		logic [N_W-1:0] n;
		logic [N_W-1:0] res;
		side_t          side;
	} sq_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} lane_t;

	typedef struct packed {
		logic       v;
		lane_t [2:0] lane;
		logic       lock_pos;
		logic       lock_neg;
		logic [1:0] order;
	} cd_t;

	function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:  r = 24'sd823550;
			5'd1:  r = 24'sd486170;
			5'd2:  r = 24'sd256879;
			5'd3:  r = 24'sd130396;
			5'd4:  r = 24'sd65451;
			5'd5:  r = 24'sd32757;
			5'd6:  r = 24'sd16383;
			5'd7:  r = 24'sd8192;
			5'd8:  r = 24'sd4096;
			5'd9:  r = 24'sd2048;
			5'd10: r = 24'sd1024;
			5'd11: r = 24'sd512;
			5'd12: r = 24'sd256;
			5'd13: r = 24'sd128;
			5'd14: r = 24'sd64;
			5'd15: r = 24'sd32;
			5'd16: r = 24'sd16;
			5'd17: r = 24'sd8;
			5'd18: r = 24'sd4;
			5'd19: r = 24'sd2;
			5'd20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Turn a negative-x vector by pi, flag the zero vector, scale by 2^16.
	function automatic lane_t prep_lane(input logic signed [XY_W-1:0] y,
	                                    input logic signed [XY_W-1:0] x);
		lane_t l;
		l.zero = (x == '0) && (y == '0);
		l.z    = '0;
		l.x    = x;
		l.y    = y;
		if (x < 0) begin
			l.z = (y >= 0) ? ZPI : -ZPI;
			l.x = -x;
			l.y = -y;
		end
		l.x = l.x <<< 16;
		l.y = l.y <<< 16;
		return l;
	endfunction

	// Round the accumulator to Q3.13 and clamp to +-pi.
	function automatic logic signed [15:0] to_q13(input lane_t l);
		logic signed [Z_W-1:0] t;
		t = (l.z + 24'sd64) >>> 7;
		if (l.zero)
			return '0;
		if (t > Z_W'(Q13_PI))
			return Q13_PI;
		if (t < -Z_W'(Q13_PI))
			return -Q13_PI;
		return t[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rme_sqrt_cell.sv =====
// One restoring square root step, registered; carries the side payload along.
// Depends on rme_pkg.
`default_nettype none
module rme_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [4:0]    k,
	input  wire rme_pkg::sq_t  d,
	output rme_pkg::sq_t       q
);
	import rme_pkg::*;

	logic           v_q;
	sq_t            d_q;
	logic [5:0]     sh;
	logic [N_W-1:0] bitv;
	logic [N_W:0]   trial;
	sq_t            nxt;

	always_comb begin
		sh    = 6'(2 * (SQ_STEPS - 1)) - {k, 1'b0};
		bitv  = N_W'(1) << sh;
		trial = {1'b0, d.res} + {1'b0, bitv};
		nxt   = d;
		if ({1'b0, d.n} >= trial) begin
			nxt.n   = d.n - trial[N_W-1:0];
			nxt.res = (d.res >> 1) + bitv;
		end else begin
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d.v;
	end

	always_ff @(posedge clk) begin
		if (en)
			d_q <= nxt;
	end

	always_comb begin
		q   = d_q;
		q.v = v_q;
	end
endmodule
`default_nettype wire

// ===== hdl/rme_cordic_cell.sv =====
// One CORDIC vectoring iteration over three lanes, registered.
// Depends on rme_pkg.
`default_nettype none
module rme_cordic_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [4:0]    step,
	input  wire rme_pkg::cd_t  d,
	output rme_pkg::cd_t       q
);
	import rme_pkg::*;

	logic v_q;
	cd_t  d_q;
	cd_t  nxt;

	always_comb begin
		nxt = d;
		for (int l = 0; l < 3; l++) begin
			if (d.lane[l].y >= 0) begin
				nxt.lane[l].x = d.lane[l].x + (d.lane[l].y >>> step);
				nxt.lane[l].y = d.lane[l].y - (d.lane[l].x >>> step);
				nxt.lane[l].z = d.lane[l].z + atan_tab(step);
			end else begin
				nxt.lane[l].x = d.lane[l].x - (d.lane[l].y >>> step);
				nxt.lane[l].y = d.lane[l].y + (d.lane[l].x >>> step);
				nxt.lane[l].z = d.lane[l].z - atan_tab(step);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d.v;
	end

	always_ff @(posedge clk) begin
		if (en)
			d_q <= nxt;
	end

	always_comb begin
		q   = d_q;
		q.v = v_q;
	end
endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_euler.sv =====
// Top level: rotation matrix (Q2.14) to Euler angles (Q3.13) via a square
// root cell chain and a CORDIC cell chain. Depends on rme_pkg and both cells.
//
// Usage:
//  - s_* channel: one 3x3 matrix per transaction, nine 16-bit Q2.14 elements.
//  - m_* channel: one transaction of three 16-bit Q3.13 angles per matrix.
//  - cfg_* channel: writes euler_order (0 XYZ, 1 XZY, 2 YZX, 3 acts as XYZ);
//    cfg_ready is always high. Write only while the block is empty.
//  - Pipeline: input register, operand select and square, 23 square root
//    cells, CORDIC prescale, CORDIC_STEPS (16) iteration cells, output
//    register.
//  - Throughput is one matrix per cycle while the receiver does not stall;
//    every cell hands its data to the next cell in each advancing cycle.
//  - When the receiver stalls with a result in the output register, the
//    whole chain holds and s_tready drops until the result is taken.
//  - Reset clears all valid bits and sets euler_order to XYZ.
`default_nettype none
module rotation_matrix_to_euler (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 16 bits each
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// angle_x, angle_y, angle_z from bit 0 up, 16 bits each
	output logic [47:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_data
);
	import rme_pkg::*;

	logic [1:0]        order_q;
	logic              adv;
	logic              v_s1;
	logic signed [15:0] m_s1 [9];
	logic [1:0]        order_s1;

	sq_t sq [SQ_STEPS+1];
	cd_t cd [CORDIC_STEPS+1];
	sq_t sq_s2;
	cd_t cd_s26;

	side_t              side_c;
	logic signed [16:0] m17 [9];
	logic signed [16:0] piv;
	logic signed [33:0] ss;
	logic [N_W-1:0]     rad;

	logic        out_v_q;
	logic [47:0] out_q;

	// Hold everything while a result waits on a stalled receiver.
	assign adv       = !out_v_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= ORD_XYZ;
		else if (cfg_valid)
			order_q <= cfg_data;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++)
				m_s1[i] <= s_tdata[16*i +: 16];
			order_s1 <= order_q;
		end
	end

	// Pick the atan2 operands and the arcsine argument for the order.
	always_comb begin
		for (int i = 0; i < 9; i++)
			m17[i] = 17'(m_s1[i]);
		side_c.order = order_s1;
		case (order_s1)
			ORD_XZY: piv = m17[1];
			ORD_YZX: piv = m17[3];
			default: piv = m17[2];
		endcase
		side_c.lock_pos = piv >= ONE_Q14;
		side_c.lock_neg = piv <= -ONE_Q14;
		case (order_s1)
			ORD_XZY: begin
				side_c.s  = -m17[1];
				side_c.ay = side_c.lock_pos || side_c.lock_neg ? -m17[6] : m17[7];
				side_c.ax = side_c.lock_pos || side_c.lock_neg ? m17[8] : m17[4];
				side_c.by = m17[2];
				side_c.bx = m17[0];
			end
			ORD_YZX: begin
				side_c.s  = m17[3];
				side_c.ay = side_c.lock_pos || side_c.lock_neg ? m17[7] : -m17[6];
				side_c.ax = side_c.lock_pos || side_c.lock_neg ? m17[8] : m17[0];
				side_c.by = -m17[5];
				side_c.bx = m17[4];
			end
			default: begin
				side_c.s  = m17[2];
				side_c.ay = side_c.lock_pos || side_c.lock_neg ? m17[3] : -m17[5];
				side_c.ax = side_c.lock_pos || side_c.lock_neg ? m17[4] : m17[8];
				side_c.by = -m17[1];
				side_c.bx = m17[0];
			end
		endcase
		// Radicand (1 - s*s) in Q.44; the lock branches never read it.
		ss = side_c.s * side_c.s;
		if (ss > 34'sd268435456)
			rad = '0;
		else
			rad = N_W'(29'd268435456 - 29'(ss)) << 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_s2.v <= 1'b0;
		else if (adv) begin
			sq_s2.v    <= v_s1;
			sq_s2.n    <= rad;
			sq_s2.res  <= '0;
			sq_s2.side <= side_c;
		end
	end

	assign sq[0] = sq_s2;

	// Square root cell chain.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		rme_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.k      (5'(k)),
			.d      (sq[k]),
			.q      (sq[k+1])
		);
	end

	// CORDIC prescale: turn negative-x vectors and scale operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cd_s26.v <= 1'b0;
		else if (adv) begin
			cd_s26.v        <= sq[SQ_STEPS].v;
			cd_s26.lane[0]  <= prep_lane(XY_W'(sq[SQ_STEPS].side.ay),
			                             XY_W'(sq[SQ_STEPS].side.ax));
			cd_s26.lane[1]  <= prep_lane(XY_W'(sq[SQ_STEPS].side.by),
			                             XY_W'(sq[SQ_STEPS].side.bx));
			cd_s26.lane[2]  <= prep_lane(XY_W'(sq[SQ_STEPS].side.s) <<< 8,
			                             XY_W'(sq[SQ_STEPS].res[22:0]));
			cd_s26.lock_pos <= sq[SQ_STEPS].side.lock_pos;
			cd_s26.lock_neg <= sq[SQ_STEPS].side.lock_neg;
			cd_s26.order    <= sq[SQ_STEPS].side.order;
		end
	end

	assign cd[0] = cd_s26;

	// CORDIC iteration cell chain.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cd
		rme_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.step   (5'(i)),
			.d      (cd[i]),
			.q      (cd[i+1])
		);
	end

	// Output select and register.
	logic signed [15:0] qa, qb, qc, sa, hp;
	logic signed [15:0] ox, oy, oz;
	logic               lock;

	always_comb begin
		qa   = to_q13(cd[CORDIC_STEPS].lane[0]);
		qb   = to_q13(cd[CORDIC_STEPS].lane[1]);
		qc   = to_q13(cd[CORDIC_STEPS].lane[2]);
		lock = cd[CORDIC_STEPS].lock_pos || cd[CORDIC_STEPS].lock_neg;
		sa   = cd[CORDIC_STEPS].lock_neg ? -qa : qa;
		hp   = cd[CORDIC_STEPS].lock_pos ? Q13_HALF_PI : -Q13_HALF_PI;
		case (cd[CORDIC_STEPS].order)
			ORD_XZY: begin
				ox = lock ? sa : qa;
				oy = lock ? 16'sd0 : qb;
				oz = lock ? -hp : qc;
			end
			ORD_YZX: begin
				ox = lock ? 16'sd0 : qb;
				oy = lock ? sa : qa;
				oz = lock ? hp : qc;
			end
			default: begin
				ox = lock ? sa : qa;
				oy = lock ? hp : qc;
				oz = lock ? 16'sd0 : qb;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= cd[CORDIC_STEPS].v;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= {oz, oy, ox};
	end

	a_lock_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cd[0].v |-> !(cd[0].lock_pos && cd[0].lock_neg))
		else $error("both lock branches flagged");

	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq[SQ_STEPS].v |-> (sq[SQ_STEPS].res <= (N_W'(1) << 22)))
		else $error("square root result out of range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(out_q[15:0]) <= Q13_PI && $signed(out_q[15:0]) >= -Q13_PI
		          && $signed(out_q[31:16]) <= Q13_PI && $signed(out_q[31:16]) >= -Q13_PI
		          && $signed(out_q[47:32]) <= Q13_PI && $signed(out_q[47:32]) >= -Q13_PI))
		else $error("output angle beyond pi");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready) |=> $stable(cd[CORDIC_STEPS]))
		else $error("chain advanced during stall");
endmodule
`default_nettype wire
